>>> src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define SHA1MH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included
`define SHA1MH_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/sha1mh_pkg.sv
`default_nettype none

package sha1mh_pkg;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [31:0] PadWord   = {PadByte, 24'h0};
  localparam logic [6:0]  RoundLast = 7'd79;
  localparam logic [6:0]  RoundSched = 7'd16;
  localparam logic [3:0]  SlotLast  = 4'd15;
  localparam logic [3:0]  SlotLenFit = 4'd13;
  localparam logic [2:0]  BytesFull = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FILL  = 4'b0010,
    S_ROUND = 4'b0100,
    S_UPD   = 4'b1000
  } state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } vars_t;

  // Last word: keep the valid leading bytes, then the pad byte
  function automatic logic [31:0] pad_word(input logic [31:0] data, input logic [2:0] cnt);
    logic [31:0] w;
    case (cnt)
      3'd1:    w = {data[31:24], PadByte, 16'h0};
      3'd2:    w = {data[31:16], PadByte, 8'h0};
      3'd3:    w = {data[31:8], PadByte};
      default: w = PadWord;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/sha1mh_round.sv
`default_nettype none

module sha1mh_round (
  input  wire sha1mh_pkg::vars_t v_i,
  input  wire logic [31:0]       w_i,
  input  wire logic [6:0]        rnd_i,
  output sha1mh_pkg::vars_t      v_o
);
  import sha1mh_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd_i inside {[7'd0:7'd19]}) begin
      f = v_i.d ^ (v_i.b & (v_i.c ^ v_i.d));
      k = K0;
    end else if (rnd_i inside {[7'd20:7'd39]}) begin
      f = v_i.b ^ v_i.c ^ v_i.d;
      k = K1;
    end else if (rnd_i inside {[7'd40:7'd59]}) begin
      f = (v_i.b & v_i.c) | (v_i.d & (v_i.b | v_i.c));
      k = K2;
    end else begin
      f = v_i.b ^ v_i.c ^ v_i.d;
      k = K3;
    end
  end

  always_comb begin
    v_o.a = {v_i.a[26:0], v_i.a[31:27]} + f + v_i.e + k + w_i;
    v_o.b = v_i.a;
    v_o.c = {v_i.b[1:0], v_i.b[31:2]};
    v_o.d = v_i.c;
    v_o.e = v_i.d;
  end

endmodule

`default_nettype wire

>>> src/sha1_message_hasher.sv
// SHA-1 hasher over a stream of big-endian 32-bit message words. Each transfer
// carries one word, its count of valid leading bytes and a last-word flag; a
// count below four is honoured only on the last word, counts above four act as
// four. Sixteen words fill a block, then one shared round unit runs the 80
// rounds at one round a cycle over a rolling 16-word schedule, and the S_UPD
// state then adds the result into the chaining words. A word that completes
// no block is accepted without holding off input; the word that completes a
// block holds off input through the rounds and the chaining update. The last
// word adds the pad byte, zero fill and the length word (bit count mod 2^32,
// high length word zero) one word a cycle, with a second block when the pad
// lands in slot 14 or 15. The digest is then one transfer on the output side,
// held in an output register so that the next message can start while it waits.

`default_nettype none

`include "assert_macros.svh"

module sha1_message_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_0_o,
  output logic [31:0]      digest_1_o,
  output logic [31:0]      digest_2_o,
  output logic [31:0]      digest_3_o,
  output logic [31:0]      digest_4_o
);
  import sha1mh_pkg::*;

  state_e      state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [3:0]  slot_q, slot_d;
  logic [31:0] len_q, len_d;
  logic        fin_q, fin_d;
  logic        pend_q, pend_d;
  logic        fit_q, fit_d;
  logic        len_done_q, len_done_d;
  logic        out_vld_q, out_vld_d;
  vars_t       h_q, h_d;
  vars_t       v_q, v_d;
  vars_t       v_rnd;
  vars_t       h_sum;
  vars_t       dig_q, dig_d;
  logic [31:0] padw_q, padw_d;
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];

  logic        in_acc;
  logic        out_free;
  logic        push;
  logic [31:0] push_w;
  logic [31:0] w_new;
  logic [31:0] w_t;
  logic [2:0]  cnt;
  vars_t       iv;

  assign iv = '{a: H0, b: H1, c: H2, d: H3, e: H4};

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign cnt        = (byte_count_i > BytesFull) ? BytesFull : byte_count_i;

  assign w_new = {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
                  win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};
  assign w_t   = (rnd_q < RoundSched) ? win_q[0] : w_new;

  sha1mh_round u_round (
    .v_i   (v_q),
    .w_i   (w_t),
    .rnd_i (rnd_q),
    .v_o   (v_rnd)
  );

  assign h_sum.a = h_q.a + v_q.a;
  assign h_sum.b = h_q.b + v_q.b;
  assign h_sum.c = h_q.c + v_q.c;
  assign h_sum.d = h_q.d + v_q.d;
  assign h_sum.e = h_q.e + v_q.e;

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    slot_d     = slot_q;
    len_d      = len_q;
    fin_d      = fin_q;
    pend_d     = pend_q;
    fit_d      = fit_q;
    len_done_d = len_done_q;
    h_d        = h_q;
    v_d        = v_q;
    dig_d      = dig_q;
    padw_d     = padw_q;
    out_vld_d  = out_vld_q && out_stall_i;
    push       = 1'b0;
    push_w     = data_word_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!last_word_i) begin
            len_d = len_q + 32'd4;
            push  = 1'b1;
            if (slot_q == SlotLast) begin
              state_d = S_ROUND;
              v_d     = h_q;
            end
          end else begin
            len_d  = len_q + {29'd0, cnt};
            fin_d  = 1'b1;
            pend_d = 1'b1;
            padw_d = pad_word(data_word_i, cnt);
            if (cnt == BytesFull) begin
              push = 1'b1;
              if (slot_q == SlotLast) begin
                state_d = S_ROUND;
                v_d     = h_q;
              end else begin
                state_d = S_FILL;
              end
            end else begin
              state_d = S_FILL;
            end
          end
        end
      end
      S_FILL: begin
        push = 1'b1;
        if (pend_q) begin
          push_w = padw_q;
          pend_d = 1'b0;
          fit_d  = (slot_q <= SlotLenFit);
        end else if (fit_q && slot_q == SlotLast) begin
          push_w     = {len_q[28:0], 3'b000};
          len_done_d = 1'b1;
        end else begin
          push_w = '0;
        end
        if (slot_q == SlotLast) begin
          state_d = S_ROUND;
          v_d     = h_q;
        end
      end
      S_ROUND: begin
        push   = 1'b1;
        push_w = w_t;
        v_d    = v_rnd;
        if (rnd_q == RoundLast) begin
          rnd_d   = '0;
          state_d = S_UPD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      S_UPD: begin
        if (fin_q && len_done_q) begin
          if (out_free) begin
            dig_d      = h_sum;
            out_vld_d  = 1'b1;
            h_d        = iv;
            len_d      = '0;
            fin_d      = 1'b0;
            fit_d      = 1'b0;
            len_done_d = 1'b0;
            state_d    = S_IDLE;
          end
        end else begin
          h_d = h_sum;
          if (fin_q) begin
            if (!pend_q) begin
              fit_d = 1'b1;
            end
            state_d = S_FILL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push) begin
      slot_d = slot_q + 4'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (push) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[15] = push_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rnd_q      <= '0;
      slot_q     <= '0;
      len_q      <= '0;
      fin_q      <= 1'b0;
      pend_q     <= 1'b0;
      fit_q      <= 1'b0;
      len_done_q <= 1'b0;
      out_vld_q  <= 1'b0;
      h_q        <= iv;
    end else begin
      state_q    <= state_d;
      rnd_q      <= rnd_d;
      slot_q     <= slot_d;
      len_q      <= len_d;
      fin_q      <= fin_d;
      pend_q     <= pend_d;
      fit_q      <= fit_d;
      len_done_q <= len_done_d;
      out_vld_q  <= out_vld_d;
      h_q        <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    dig_q  <= dig_d;
    padw_q <= padw_d;
    for (int i = 0; i < 16; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  assign out_valid_o = out_vld_q;
  assign digest_0_o  = dig_q.a;
  assign digest_1_o  = dig_q.b;
  assign digest_2_o  = dig_q.c;
  assign digest_3_o  = dig_q.d;
  assign digest_4_o  = dig_q.e;

  `SHA1MH_ASSERT(a_rnd_only_in_round, (rnd_q != 7'd0) |-> (state_q == S_ROUND), "round count outside rounds")
  `SHA1MH_ASSERT(a_round_to_upd, (state_q == S_ROUND && rnd_q == RoundLast) |=> (state_q == S_UPD), "no chaining update after last round")
  `SHA1MH_ASSERT(a_len_after_pad, len_done_q |-> (fin_q && !pend_q), "length word before pad")
  `SHA1MH_ASSERT_NR(a_digest_from_upd, $rose(out_vld_q) |-> $past(state_q == S_UPD), "digest not from chaining update")

endmodule

`default_nettype wire

>>> tb/tb_sha1_message_hasher.sv
module tb_sha1_message_hasher;
  import sha1mh_pkg::*;

  typedef logic [4:0][31:0] digest_t;
  typedef enum {RX_OPEN, RX_SPARSE, RX_BEAT, RX_HEAVY} rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] data_word_i;
  logic [2:0]  byte_count_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_0_o;
  logic [31:0] digest_1_o;
  logic [31:0] digest_2_o;
  logic [31:0] digest_3_o;
  logic [31:0] digest_4_o;

  sha1_message_hasher dut (.*);

  // predictor state
  logic [31:0] chain_h [5];
  logic [31:0] sched_w [16];
  logic [31:0] msg_bytes;
  int          fill_slot;

  digest_t     expected_digests [$];
  digest_t     got_digest;
  digest_t     want_digest;
  int          fail_count = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          rx_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_sha1_message_hasher failed");
    $finish;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_message();
    chain_h[0] = H0;
    chain_h[1] = H1;
    chain_h[2] = H2;
    chain_h[3] = H3;
    chain_h[4] = H4;
    msg_bytes  = '0;
    fill_slot  = 0;
  endfunction

  function automatic void sha1_rounds();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = d ^ (b & (c ^ d));
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c));
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      if (r >= 16) begin
        sched_w[r % 16] = rotl(sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16] ^
                               sched_w[(r + 2) % 16] ^ sched_w[r % 16], 1);
      end
      w = sched_w[r % 16];
      t = rotl(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void load_schedule_word(input logic [31:0] w);
    sched_w[fill_slot] = w;
    fill_slot = (fill_slot + 1) % 16;
    if (fill_slot == 0) sha1_rounds();
  endfunction

  // advance the predictor by one accepted word; queue a digest on the last one
  function automatic void hash_word(input logic [31:0] data, input logic [2:0] cnt_in,
                                    input logic last);
    int          nb;
    int          slot;
    logic [31:0] pad_w;
    digest_t     dg;
    nb = (cnt_in > BytesFull) ? 4 : int'(cnt_in);
    if (!last) begin
      msg_bytes += 4;
      load_schedule_word(data);
      return;
    end
    msg_bytes += nb;
    if (nb == 4) begin
      load_schedule_word(data);
      pad_w = PadWord;
    end else if (nb == 0) begin
      pad_w = PadWord;
    end else begin
      pad_w = (data & (32'hFFFF_FFFF << (32 - 8 * nb))) | ({24'h0, PadByte} << (24 - 8 * nb));
    end
    slot = fill_slot;
    sched_w[slot] = pad_w;
    for (int j = slot + 1; j < 16; j++) sched_w[j] = '0;
    // no room for the length: close this block, length goes in a second one
    if (slot > 13) begin
      sha1_rounds();
      for (int j = 0; j < 16; j++) sched_w[j] = '0;
    end
    sched_w[14] = '0;
    sched_w[15] = {msg_bytes[28:0], 3'b000};
    sha1_rounds();
    for (int j = 0; j < 5; j++) dg[j] = chain_h[j];
    expected_digests.push_back(dg);
    restart_message();
  endfunction

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_stall_i <= 1'b0;
      RX_SPARSE: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_BEAT:   out_stall_i <= ((rx_left % 5) < 2);
      default:   out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // digest checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_digest = {digest_4_o, digest_3_o, digest_2_o, digest_1_o, digest_0_o};
      if (expected_digests.size() == 0) begin
        $error("digest transfer with none expected: %h", got_digest);
        fail_count++;
      end else begin
        want_digest = expected_digests.pop_front();
        for (int j = 0; j < 5; j++) begin
          if (got_digest[j] !== want_digest[j]) begin
            $error("digest_%0d: expected %h, got %h", j, want_digest[j], got_digest[j]);
            fail_count++;
          end
        end
      end
    end
  end

  // one input transfer; valid stays high afterwards unless a gap follows
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    data_word_i  <= data;
    byte_count_i <= cnt;
    last_word_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    hash_word(data, cnt, last);
    words_sent++;
  endtask

  task automatic drain_digests();
    in_valid_i <= 1'b0;
    wait (expected_digests.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic test_empty_message();
    send_word($urandom, 3'd0, 1'b1);
  endtask

  task automatic test_short_last_words();
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
  endtask

  task automatic test_saturated_counts();
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
    send_word($urandom, 3'd6, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
  endtask

  task automatic test_full_last_word();
    send_word(32'h0000_0000, BytesFull, 1'b1);
  endtask

  task automatic test_ignored_short_counts();
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'h0000_0000, 3'd7, 1'b0);
    send_word(32'hA5A5_5A5A, BytesFull, 1'b1);
  endtask

  // full last word in slot 13 pushes the pad into slot 14: two closing blocks
  task automatic test_pad_second_block();
    for (int j = 0; j < 13; j++)
      send_word((j % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, BytesFull, 1'b1);
    drain_digests();
  endtask

  task automatic test_random_messages();
    int n;
    int pick;
    while (words_sent < 1900) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)      n = $urandom_range(0, 20);
      else if (pick < 93) n = 16 * $urandom_range(0, 2) + $urandom_range(13, 15);
      else                n = $urandom_range(32, 70);
      for (int j = 0; j < n; j++)
        send_word($urandom,
                  ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : BytesFull, 1'b0);
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
      if ($urandom_range(0, 24) == 0) drain_digests();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_word_i  = 1'b0;
    restart_message();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_short_last_words();
    test_saturated_counts();
    test_full_last_word();
    test_ignored_short_counts();
    test_pad_second_block();
    test_random_messages();

    in_valid_i <= 1'b0;
    wait (expected_digests.size() == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_sha1_message_hasher passed");
    end else begin
      $display("tb_sha1_message_hasher failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sha1mh_pkg.sv
src/sha1mh_round.sv
src/sha1_message_hasher.sv
tb/tb_sha1_message_hasher.sv
